/* rtl/kp_pkg.sv */
// Package with the shared types, constants and key map of the keypad entry block.
`timescale 1ns / 1ps
package kp_pkg;

  localparam int unsigned RowW    = 4;
  localparam int unsigned ColW    = 3;
  localparam int unsigned CharW   = 7;
  localparam int unsigned NumW    = 7;
  localparam int unsigned TickW   = 16;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned CfgDatW = 16;

  localparam logic [7:0]  SettleReset  = 8'd5;
  localparam logic [15:0] TimeoutReset = 16'd1000;
  localparam logic [7:0]  GuardReset   = 8'd20;
  localparam logic [15:0] GapReset     = 16'd300;

  localparam logic [ColW-1:0]  ColsIdle = 3'b111;
  localparam logic [RowW-1:0]  RowsIdle = 4'b1111;
  localparam logic [CharW-1:0] ChZero   = 7'h30;
  localparam logic [CharW-1:0] ChNine   = 7'h39;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_SETTLE  = 8'd0,
    CFG_TIMEOUT = 8'd1,
    CFG_GUARD   = 8'd2,
    CFG_GAP     = 8'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PH_SETTLE  = 2'd0,
    PH_RELEASE = 2'd1,
    PH_GUARD   = 2'd2,
    PH_GAP     = 2'd3
  } phase_t;

  typedef struct packed {
    logic [RowW-1:0] row_sense;
  } kp_in_t;

  typedef struct packed {
    logic [ColW-1:0]  col_drive;
    logic             key_valid;
    logic [CharW-1:0] key_char;
    logic             number_valid;
    logic [NumW-1:0]  number_value;
  } kp_out_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [CfgDatW-1:0] value;
  } kp_cfg_wr_t;

  // Current register values handed to the scan core.
  typedef struct packed {
    logic [7:0]  settle_ticks;
    logic [15:0] release_timeout;
    logic [7:0]  release_guard;
    logic [15:0] digit_gap;
  } kp_cfg_t;

  // Key map: rows A..D, columns 1..3. A column code of 3 reads as column 1.
  function automatic logic [CharW-1:0] key_lookup(input logic [1:0] row, input logic [1:0] col);
    logic [CharW-1:0] ch;
    ch = 7'h00;
    unique case ({row, col})
      4'b00_00, 4'b00_11: ch = 7'h31;
      4'b00_01:           ch = 7'h32;
      4'b00_10:           ch = 7'h33;
      4'b01_00, 4'b01_11: ch = 7'h34;
      4'b01_01:           ch = 7'h35;
      4'b01_10:           ch = 7'h36;
      4'b10_00, 4'b10_11: ch = 7'h37;
      4'b10_01:           ch = 7'h38;
      4'b10_10:           ch = 7'h39;
      4'b11_00, 4'b11_11: ch = 7'h2A;
      4'b11_01:           ch = 7'h30;
      4'b11_10:           ch = 7'h23;
      default:            ch = 7'h00;
    endcase
    return ch;
  endfunction

endpackage

/* rtl/kp_stream_if.sv */
// Valid/ready channel interface used for the row, result and configuration channels.
`timescale 1ns / 1ps
interface kp_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/kp_cfg_regs.sv */
// Configuration register file for the keypad entry block.
`timescale 1ns / 1ps
module kp_cfg_regs import kp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       wr_en,
  input  kp_cfg_wr_t wr,
  output kp_cfg_t    cfg
);

  kp_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.settle_ticks    <= SettleReset;
      cfg_r.release_timeout <= TimeoutReset;
      cfg_r.release_guard   <= GuardReset;
      cfg_r.digit_gap       <= GapReset;
    end else if (wr_en) begin
      case (wr.index)
        CFG_SETTLE:  cfg_r.settle_ticks    <= wr.value[7:0];
        CFG_TIMEOUT: cfg_r.release_timeout <= wr.value;
        CFG_GUARD:   cfg_r.release_guard   <= wr.value[7:0];
        CFG_GAP:     cfg_r.digit_gap       <= wr.value;
        default:     ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

/* rtl/kp_scan_core.sv */
// Scan state machine: one tick of column scan, release wait, guard, gap pause and digit pairing.
`timescale 1ns / 1ps
module kp_scan_core import kp_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step,
  input  logic [RowW-1:0] rows,
  input  kp_cfg_t         cfg,
  output kp_out_t         result
);

  phase_t           phase_r, phase_nxt;
  logic [1:0]       col_r, col_nxt;
  logic [TickW-1:0] tick_r, tick_nxt;
  logic [1:0]       hit_r, hit_nxt;
  logic [3:0]       first_r, first_nxt;
  logic             have_first_r, have_first_nxt;

  logic [TickW:0]   next_cnt;
  logic             settle_done, release_done, guard_done, gap_done;
  logic             any_hit;
  logic [1:0]       hit_row;
  logic             report;
  logic [CharW-1:0] ch;
  logic             is_digit;
  logic [3:0]       digit;
  logic [NumW-1:0]  number;

  assign next_cnt     = {1'b0, tick_r} + {{TickW{1'b0}}, 1'b1};
  assign settle_done  = next_cnt >= {9'd0, cfg.settle_ticks};
  assign release_done = (rows == RowsIdle) || (next_cnt >= {1'b0, cfg.release_timeout});
  assign guard_done   = next_cnt >= {9'd0, cfg.release_guard};
  assign gap_done     = next_cnt >= {1'b0, cfg.digit_gap};
  assign any_hit      = rows != RowsIdle;

  always_comb begin
    priority if (!rows[0]) hit_row = 2'd0;
    else if (!rows[1])     hit_row = 2'd1;
    else if (!rows[2])     hit_row = 2'd2;
    else                   hit_row = 2'd3;
  end

  // A key is reported when the release wait ends with no guard, or the guard ends.
  assign report = ((phase_r == PH_RELEASE) && release_done && (cfg.release_guard == 8'd0)) ||
                  ((phase_r == PH_GUARD) && guard_done);

  assign ch       = key_lookup(hit_r, col_r);
  assign is_digit = (ch >= ChZero) && (ch <= ChNine);
  assign digit    = 4'(ch - ChZero);
  assign number   = {first_r, 3'b000} + {2'b00, first_r, 1'b0} + {3'b000, digit};

  // Next state.
  always_comb begin
    phase_nxt      = phase_r;
    col_nxt        = col_r;
    tick_nxt       = next_cnt[TickW-1:0];
    hit_nxt        = hit_r;
    first_nxt      = first_r;
    have_first_nxt = have_first_r;
    if (col_r == 2'd3) begin
      // Column code outside the scan restarts the scan.
      phase_nxt = PH_SETTLE;
      col_nxt   = 2'd0;
      tick_nxt  = '0;
    end else if (report) begin
      tick_nxt = '0;
      if (is_digit) begin
        have_first_nxt = !have_first_r;
        if (!have_first_r) begin
          first_nxt = digit;
        end
        if (cfg.digit_gap == 16'd0) begin
          phase_nxt = PH_SETTLE;
          col_nxt   = 2'd0;
        end else begin
          phase_nxt = PH_GAP;
        end
      end else begin
        phase_nxt = PH_SETTLE;
        col_nxt   = 2'd0;
      end
    end else begin
      unique case (phase_r)
        PH_SETTLE: begin
          if (settle_done) begin
            tick_nxt = '0;
            if (any_hit) begin
              hit_nxt   = hit_row;
              phase_nxt = PH_RELEASE;
            end else begin
              col_nxt = (col_r == 2'd2) ? 2'd0 : col_r + 2'd1;
            end
          end
        end
        PH_RELEASE: begin
          if (release_done) begin
            tick_nxt  = '0;
            phase_nxt = PH_GUARD;
          end
        end
        PH_GUARD: ;
        PH_GAP: begin
          if (gap_done) begin
            phase_nxt = PH_SETTLE;
            col_nxt   = 2'd0;
            tick_nxt  = '0;
          end
        end
        default: ;
      endcase
    end
  end

  // Outputs of this tick.
  always_comb begin
    result              = '0;
    result.col_drive    = (phase_nxt == PH_GAP) ? ColsIdle : ~(3'b001 << col_nxt);
    result.key_valid    = report && (col_r != 2'd3);
    result.key_char     = result.key_valid ? ch : '0;
    result.number_valid = result.key_valid && is_digit && have_first_r;
    result.number_value = result.number_valid ? number : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_SETTLE;
      col_r        <= 2'd0;
      tick_r       <= '0;
      hit_r        <= 2'd0;
      first_r      <= 4'd0;
      have_first_r <= 1'b0;
    end else if (step) begin
      phase_r      <= phase_nxt;
      col_r        <= col_nxt;
      tick_r       <= tick_nxt;
      hit_r        <= hit_nxt;
      first_r      <= first_nxt;
      have_first_r <= have_first_nxt;
    end
  end

  a_number_needs_key: assert property (@(posedge clk) disable iff (!rst_n)
    result.number_valid |-> result.key_valid)
    else $error("number reported without a key");

  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    col_r != 2'd3)
    else $error("column index out of range");

  a_digit_gap: assert property (@(posedge clk) disable iff (!rst_n)
    step && result.key_valid && is_digit && (cfg.digit_gap != 16'd0) |=> phase_r == PH_GAP)
    else $error("accepted digit did not start the gap pause");

  a_symbol_restart: assert property (@(posedge clk) disable iff (!rst_n)
    step && result.key_valid && !is_digit |=> (phase_r == PH_SETTLE) && (col_r == 2'd0))
    else $error("star or hash did not restart the scan");

  a_pairing_toggles: assert property (@(posedge clk) disable iff (!rst_n)
    step && result.key_valid && is_digit |=> have_first_r != $past(have_first_r))
    else $error("digit pairing did not advance");

endmodule

/* rtl/matrix_keypad_two_digit_entry.sv */
// Top level of the 4x3 matrix keypad scanner with two-digit number entry.
// A row transaction reaches the result channel through the input register and then the result register.
// Throughput: one transaction per clock cycle while the result side keeps up; scan state logic is short.
// Every accepted row sample yields exactly one result transaction carrying the column drive.
// Reset (rst_n low at a clock edge) clears the scan to column 1 settle, the digit pairing and both
// channel stages, and loads the register defaults: settle 5, timeout 1000, guard 20, gap 300.
`timescale 1ns / 1ps
module matrix_keypad_two_digit_entry import kp_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  kp_stream_if.sink   in_if,
  kp_stream_if.source out_if,
  kp_stream_if.sink   cfg_if
);

  // Input stage: holds one row sample until the scan core takes it.
  logic            in_valid_r;
  logic [RowW-1:0] in_rows_r;

  // Result stage: holds one result until the sink takes it.
  logic            out_valid_r;
  kp_out_t         out_data_r;

  logic            advance;
  kp_cfg_t         cfg;
  kp_out_t         core_result;
  kp_cfg_wr_t      cfg_wr;

  // The core steps whenever a sample is held and the result stage is free or draining, so a new
  // transaction is accepted every cycle while the result side keeps up.
  assign advance      = in_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready  = !in_valid_r || advance;
  assign out_if.valid = out_valid_r;
  assign out_if.data  = out_data_r;

  // Configuration writes are always taken; they land in the register file at once.
  assign cfg_if.ready = 1'b1;
  assign cfg_wr       = cfg_if.data;

  kp_cfg_regs u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .wr_en (cfg_if.valid),
    .wr    (cfg_wr),
    .cfg   (cfg)
  );

  kp_scan_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .rows   (in_rows_r),
    .cfg    (cfg),
    .result (core_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      in_rows_r <= in_if.data.row_sense;
    end
    if (advance) begin
      out_data_r <= core_result;
    end
  end

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_if.ready |=> out_valid_r && $stable(out_data_r))
    else $error("stalled result changed");

  a_sample_not_lost: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !advance |=> in_valid_r && $stable(in_rows_r))
    else $error("waiting row sample lost");

  a_step_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("core step produced no result");

endmodule

/* verif/matrix_keypad_two_digit_entry_tb.sv */
// Self-checking testbench for the keypad scanner with two-digit number entry.
`timescale 1ns / 1ps
module matrix_keypad_two_digit_entry_tb;
  import kp_pkg::*;

  // Keys in row-major order: row A is "123", row D is "*0#".
  localparam string KeyLayout = "123456789*0#";

  logic clk;
  logic rst_n;

  kp_stream_if #(.payload_t(kp_in_t))     in_ch  ();
  kp_stream_if #(.payload_t(kp_out_t))    out_ch ();
  kp_stream_if #(.payload_t(kp_cfg_wr_t)) cfg_ch ();

  matrix_keypad_two_digit_entry u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  // Free-running 8 ns clock.
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Row samples waiting to be driven, and the tick results predicted for
  // every row transaction the block has taken but not yet answered.
  logic [RowW-1:0] row_q[$];
  kp_out_t         tick_result_q[$];

  int unsigned rows_offered;
  int unsigned rows_accepted;
  int unsigned results_seen;
  int unsigned results_acked;
  int unsigned row_wait;
  int unsigned ready_wait;
  int unsigned idle_max;
  int unsigned errors;
  int unsigned keys_seen;
  int unsigned numbers_seen;
  int unsigned reg_writes;
  logic        hold_results;

  // Shadow of the scanner: register copies and scan state.
  logic [7:0]  cf_settle;
  logic [15:0] cf_timeout;
  logic [7:0]  cf_guard;
  logic [15:0] cf_gap;
  phase_t      sc_phase;
  logic [1:0]  sc_col;
  logic [15:0] sc_ticks;
  logic [1:0]  sc_row;
  logic [3:0]  pend_digit;
  logic        pend_valid;

  function automatic void restart_scan();
    sc_phase = PH_SETTLE;
    sc_col   = 2'd0;
    sc_ticks = 16'd0;
  endfunction

  // Reports the key under the hit row and current column. Digits are paired
  // into a number and wait out a nonzero gap; star and hash restart the scan.
  function automatic void emit_key(inout kp_out_t r);
    logic [7:0] ch;
    logic [3:0] d;
    ch = KeyLayout[sc_row * 3 + ((sc_col <= 2'd2) ? sc_col : 0)];
    r.key_valid = 1'b1;
    r.key_char  = ch[6:0];
    if (ch >= "0" && ch <= "9") begin
      d = 4'(ch - "0");
      if (pend_valid) begin
        r.number_valid = 1'b1;
        r.number_value = pend_digit * 7'd10 + 7'(d);
        pend_valid     = 1'b0;
      end else begin
        pend_digit = d;
        pend_valid = 1'b1;
      end
      if (cf_gap == 16'd0) begin
        restart_scan();
      end else begin
        sc_phase = PH_GAP;
        sc_ticks = 16'd0;
      end
    end else begin
      restart_scan();
    end
  endfunction

  // Advances the shadow scanner by one tick and returns the tick's result.
  function automatic kp_out_t scan_tick(input logic [RowW-1:0] rows);
    kp_out_t     r;
    logic [16:0] nxt;
    logic [1:0]  hit;
    r   = '0;
    nxt = {1'b0, sc_ticks} + 17'd1;
    if (sc_col > 2'd2) restart_scan();
    case (sc_phase)
      PH_SETTLE: begin
        if (nxt >= {9'd0, cf_settle}) begin
          sc_ticks = 16'd0;
          if (rows != RowsIdle) begin
            // Row A has the highest priority, so scan downward from D.
            hit = 2'd0;
            for (int i = 3; i >= 0; i--) begin
              if (!rows[i]) hit = 2'(i);
            end
            sc_row   = hit;
            sc_phase = PH_RELEASE;
          end else begin
            sc_col = (sc_col >= 2'd2) ? 2'd0 : sc_col + 2'd1;
          end
        end else begin
          sc_ticks = nxt[15:0];
        end
      end
      PH_RELEASE: begin
        if (rows == RowsIdle || nxt >= {1'b0, cf_timeout}) begin
          sc_ticks = 16'd0;
          if (cf_guard == 8'd0) emit_key(r);
          else sc_phase = PH_GUARD;
        end else begin
          sc_ticks = nxt[15:0];
        end
      end
      PH_GUARD: begin
        if (nxt >= {9'd0, cf_guard}) begin
          sc_ticks = 16'd0;
          emit_key(r);
        end else begin
          sc_ticks = nxt[15:0];
        end
      end
      default: begin
        if (nxt >= {1'b0, cf_gap}) restart_scan();
        else sc_ticks = nxt[15:0];
      end
    endcase
    r.col_drive = (sc_phase == PH_GAP) ? ColsIdle : (ColsIdle & ~(3'b001 << sc_col));
    return r;
  endfunction

  // Row driver: offers the next sample at the falling edge, holds it until
  // the block takes it, then idles for a freshly drawn number of cycles.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && rows_accepted != rows_offered) begin
      // The current transaction is still waiting for ready.
    end else if (row_wait != 0) begin
      row_wait--;
      in_ch.valid <= 1'b0;
    end else if (row_q.size() != 0) begin
      in_ch.data.row_sense <= row_q.pop_front();
      in_ch.valid          <= 1'b1;
      rows_offered++;
      row_wait = $urandom_range(0, idle_max);
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  // Result sink: after every result it draws a number of cycles to hold
  // ready low. The long hold-off process can override it.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (results_seen != results_acked) begin
        results_acked = results_seen;
        ready_wait    = $urandom_range(0, idle_max);
      end
      if (hold_results || ready_wait != 0) begin
        out_ch.ready <= 1'b0;
        if (ready_wait != 0) ready_wait--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Monitor: every row transaction is run through the shadow scanner, and
  // every result transaction is compared with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (tick_result_q.size() == 0) begin
          errors++;
          $display("%0t ns: result with nothing expected: col=%0h key=%0b/%0h num=%0b/%0d",
                   $time, out_ch.data.col_drive, out_ch.data.key_valid,
                   out_ch.data.key_char, out_ch.data.number_valid, out_ch.data.number_value);
        end else begin
          if (out_ch.data !== tick_result_q[0]) begin
            errors++;
            $display("%0t ns: mismatch expected col=%0h key=%0b/%0h num=%0b/%0d, %s",
                     $time, tick_result_q[0].col_drive, tick_result_q[0].key_valid,
                     tick_result_q[0].key_char, tick_result_q[0].number_valid,
                     tick_result_q[0].number_value, "got:");
            $display("%0t ns:          actual col=%0h key=%0b/%0h num=%0b/%0d",
                     $time, out_ch.data.col_drive, out_ch.data.key_valid,
                     out_ch.data.key_char, out_ch.data.number_valid,
                     out_ch.data.number_value);
          end
          if (tick_result_q[0].key_valid) keys_seen++;
          if (tick_result_q[0].number_valid) numbers_seen++;
          void'(tick_result_q.pop_front());
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        tick_result_q.push_back(scan_tick(in_ch.data.row_sense));
        rows_accepted++;
      end
    end
  end

  // One register write transaction on the configuration channel. The shadow
  // copy is updated at the edge that takes the transaction.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDatW-1:0] val);
    @(negedge clk);
    cfg_ch.data  <= {idx, val};
    cfg_ch.valid <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      CFG_SETTLE:  cf_settle  = val[7:0];
      CFG_TIMEOUT: cf_timeout = val;
      CFG_GUARD:   cf_guard   = val[7:0];
      CFG_GAP:     cf_gap     = val;
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_config(input logic [15:0] settle, input logic [15:0] timeout,
                            input logic [15:0] guard, input logic [15:0] gap);
    write_reg(CFG_SETTLE, settle);
    write_reg(CFG_TIMEOUT, timeout);
    write_reg(CFG_GUARD, guard);
    write_reg(CFG_GAP, gap);
  endtask

  // Waits until every queued row was taken and every result came back.
  task automatic drain();
    while (!(row_q.size() == 0 && rows_offered == rows_accepted &&
             tick_result_q.size() == 0)) begin
      @(posedge clk);
    end
  endtask

  // Queues keypresses: a quiet stretch, a held row pattern, then a release.
  // About one sequence in five is replaced by bouncy noise. The span scales
  // the stretches to the settle time so that presses land on every column.
  task automatic queue_keying(input int unsigned n, input int unsigned span);
    int unsigned pushed;
    int unsigned quiet;
    int unsigned hold;
    int unsigned rel;
    logic [3:0]  pat;
    pushed = 0;
    while (pushed < n) begin
      if ($urandom_range(0, 4) == 0) begin
        rel = $urandom_range(1, 4);
        repeat (rel) row_q.push_back(4'($urandom));
        pushed += rel;
      end else begin
        quiet = $urandom_range(0, 2 * span);
        hold  = $urandom_range(1, 3 * span + 3);
        rel   = $urandom_range(1, span + 6);
        if ($urandom_range(0, 3) == 0) pat = 4'($urandom);
        else pat = ~(4'b0001 << $urandom_range(0, 3));
        repeat (quiet) row_q.push_back(RowsIdle);
        repeat (hold) row_q.push_back(pat);
        repeat (rel) row_q.push_back(RowsIdle);
        pushed += quiet + hold + rel;
      end
    end
  endtask

  // Long receiver hold-off in the middle of the no-idle phase: rows keep
  // coming, so the block fills up and must stall its input.
  initial begin
    hold_results = 1'b0;
    while (rows_accepted < 200) @(posedge clk);
    hold_results = 1'b1;
    repeat (60) @(posedge clk);
    hold_results = 1'b0;
  end

  // Stimulus sequencer.
  initial begin
    logic [15:0] s;
    in_ch.valid          = 1'b0;
    in_ch.data.row_sense = RowsIdle;
    out_ch.ready         = 1'b0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.data          = '0;
    rst_n                = 1'b0;
    rows_offered         = 0;
    rows_accepted        = 0;
    results_seen         = 0;
    results_acked        = 0;
    row_wait             = 0;
    ready_wait           = 0;
    idle_max             = 0;
    errors               = 0;
    keys_seen            = 0;
    numbers_seen         = 0;
    reg_writes           = 0;
    cf_settle            = SettleReset;
    cf_timeout           = TimeoutReset;
    cf_guard             = GuardReset;
    cf_gap               = GapReset;
    sc_row               = 2'd0;
    pend_digit           = 4'd0;
    pend_valid           = 1'b0;
    restart_scan();

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed walk with a zero settle time, zero guard and zero gap, so each
    // sample hits the column that is being driven. It presses 1 and 0 to form
    // a number, then hash, then 9, then 2 with all rows low on column 2
    // (row A wins) and finally star.
    set_config(16'd0, TimeoutReset, 16'd0, 16'd0);
    row_q.push_back(4'hE); row_q.push_back(4'hF);
    row_q.push_back(4'hF); row_q.push_back(4'h7); row_q.push_back(4'hF);
    row_q.push_back(4'hF); row_q.push_back(4'hF); row_q.push_back(4'h7);
    row_q.push_back(4'hF);
    row_q.push_back(4'hF); row_q.push_back(4'hF); row_q.push_back(4'hB);
    row_q.push_back(4'hF);
    row_q.push_back(4'hF); row_q.push_back(4'h0); row_q.push_back(4'hF);
    row_q.push_back(4'h7); row_q.push_back(4'hF);
    drain();

    // A zero release timeout still spends one tick waiting for release.
    write_reg(CFG_TIMEOUT, 16'd0);
    row_q.push_back(4'hB); row_q.push_back(4'hB); row_q.push_back(4'hF);
    drain();

    // Random keying under a range of settings, starting with quick scans.
    set_config(16'd1, 16'd4, 16'd0, 16'd0);
    idle_max = 10;
    queue_keying(120, 1);
    drain();

    // Upper byte of an 8-bit register is ignored. No idling on either side.
    set_config(16'hFF02, 16'd10, 16'h5A03, 16'd5);
    idle_max = 0;
    queue_keying(150, 2);
    drain();

    set_config(16'(SettleReset), TimeoutReset, 16'(GuardReset), GapReset);
    idle_max = 10;
    queue_keying(200, 5);
    drain();

    // Writes to unused indexes must leave every register unchanged.
    write_reg(8'h04, 16'h0001);
    write_reg(8'hFF, 16'hFFFF);
    set_config(16'd255, 16'd65535, 16'd255, 16'd65535);
    queue_keying(60, 20);
    drain();

    repeat (5) begin
      s = {8'($urandom), 8'($urandom_range(0, 4))};
      set_config(s, 16'($urandom_range(0, 20)), 16'($urandom_range(0, 6)),
                 16'($urandom_range(0, 12)));
      idle_max = $urandom_range(0, 10);
      queue_keying(100, s[7:0] + 1);
      drain();
    end

    // Spare cycles at the end catch any stray result.
    repeat (8) @(posedge clk);
    $display("Covered %0d row ticks over %0d register writes.", rows_accepted, reg_writes);
    $display("Saw %0d key reports and %0d completed numbers.", keys_seen, numbers_seen);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
